// ===== design/cmsc_pkg.sv =====
// Shared constants and types for the clock mult/shift calculation block
`default_nettype none
package cmsc_pkg;
   localparam logic [31:0] NS_PER_SEC     = 32'd1000000000;
   localparam logic [31:0] MIN_MARGIN     = 32'd200000;
   localparam logic [31:0] DEFAULT_MARGIN = 32'd31250000;
   // ceil(11 * 2^36 / 100): exact floor(11 * m / 100) for any 32-bit m
   localparam logic [32:0] ADJ_RECIP      = 33'd7559142441;

   // Divider start request
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   // Divider status
   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

   function automatic logic [31:0] adjust_of(input logic [31:0] m);
      logic [64:0] p;
      begin
         p = {33'd0, m} * {32'd0, ADJ_RECIP};
         adjust_of = {3'd0, p[64:36]};
      end
   endfunction
endpackage
`default_nettype wire

// ===== design/cmsc_div.sv =====
// Radix-2 restoring 64-bit divider, one quotient bit per cycle
`default_nettype none
module cmsc_div
   import cmsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]} - {1'b0, dvs_ff};
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule
`default_nettype wire

// ===== design/cmsc_seq.sv =====
// Sequencer driving the shared divider through the mult/shift calculation
`default_nettype none
module cmsc_seq
   import cmsc_pkg::*;
#(
   parameter int MAX_RANGE_SEC = 600
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_counter_mask,
   input  wire logic [19:0] req_scale,
   input  wire logic [31:0] req_freq,
   input  wire logic [31:0] req_given_margin,
   input  wire logic [31:0] req_preset_mult,
   input  wire logic [5:0]  req_preset_shift,
   output logic             res_valid,
   input  wire logic        res_taken,
   output logic [31:0]      res_mult,
   output logic [5:0]       res_shift,
   output logic [31:0]      res_adj,
   output logic [63:0]      res_maxcyc,
   output logic [63:0]      res_ns,
   output logic [31:0]      res_margin,
   output logic             res_ovf,
   output div_req_type      dreq,
   input  wire div_rsp_type drsp
);
   localparam logic [63:0] RANGE_CAP = 64'(MAX_RANGE_SEC);
   localparam logic [4:0] S_IDLE = 5'd0, S_SEC1 = 5'd1, S_SEC2 = 5'd2, S_TO = 5'd3,
      S_RNG = 5'd4, S_RNG2 = 5'd5, S_ACC = 5'd6, S_ACC2 = 5'd7, S_SRCH = 5'd8,
      S_SRCHW = 5'd9, S_MARG = 5'd10, S_MARGW = 5'd11, S_HALF = 5'd12,
      S_MCYC = 5'd13, S_MCYCW = 5'd14, S_NS = 5'd15, S_NS2 = 5'd16, S_DONE = 5'd17,
      S_RNGW = 5'd18, S_SECW = 5'd19;

   logic [4:0]  st_ff, st_in;
   logic [63:0] mask_ff;
   logic [19:0] scale_ff;
   logic [31:0] freq_ff, margin_ff, margin_in, mult_ff, mult_in, to_ff, to_in;
   logic [31:0] range_ff, range_in, adj_ff, adj_in;
   logic [5:0]  shift_ff, shift_in, acc_ff, acc_in, sh_ff, sh_in;
   logic [63:0] sec_ff, sec_in, t_ff, t_in, cyc_ff, cyc_in, ns_ff, ns_in;
   logic        dz_ff, dz_in;
   logic        go;
   logic [63:0] prod;
   logic [64:0] cand64;
   logic [32:0] sum;
   logic [31:0] diff;
   logic [63:0] nsp;

   assign go        = req_valid && !req_stall;
   assign req_stall = (st_ff != S_IDLE);
   assign sum       = {1'b0, mult_ff} + {1'b0, adj_ff};
   assign diff      = mult_ff - adj_ff;
   assign prod      = {32'd0, sec_ff[31:0]} * {44'd0, scale_ff};
   assign cand64    = {1'b0, drsp.quotient} >> acc_ff;
   assign nsp       = cyc_ff[31:0] * diff;

   always_comb begin
      st_in = st_ff;
      margin_in = margin_ff;
      mult_in = mult_ff;
      shift_in = shift_ff;
      to_in = to_ff;
      range_in = range_ff;
      adj_in = adj_ff;
      acc_in = acc_ff;
      sh_in = sh_ff;
      sec_in = sec_ff;
      t_in = t_ff;
      cyc_in = cyc_ff;
      ns_in = ns_ff;
      dz_in = dz_ff;
      dreq = '0;
      case (st_ff)
         S_IDLE: begin
            if (go) begin
               margin_in = req_given_margin;
               mult_in = req_preset_mult;
               shift_in = req_preset_shift;
               dz_in = 1'b0;
               st_in = (req_freq != 32'd0) ? S_SEC1 : S_MARG;
            end
         end
         S_SEC1: begin
            dreq.start = 1'b1;
            dreq.dividend = mask_ff;
            dreq.divisor = {32'd0, freq_ff};
            st_in = S_SECW;
         end
         S_SECW: begin
            if (drsp.done) begin
               if (scale_ff == 20'd0) begin
                  sec_in = '1;
                  to_in = '1;
                  dz_in = 1'b1;
                  st_in = S_RNG;
               end else begin
                  dreq.start = 1'b1;
                  dreq.dividend = drsp.quotient;
                  dreq.divisor = {44'd0, scale_ff};
                  st_in = S_SEC2;
               end
            end
         end
         S_SEC2: begin
            if (drsp.done) begin
               sec_in = drsp.quotient;
               dreq.start = 1'b1;
               dreq.dividend = {32'd0, NS_PER_SEC};
               dreq.divisor = {44'd0, scale_ff};
               st_in = S_TO;
            end
         end
         S_TO: begin
            if (drsp.done) begin
               to_in = drsp.quotient[31:0];
               st_in = S_RNG;
            end
         end
         S_RNG: begin
            if (sec_ff == 64'd0) sec_in = 64'd1;
            else if (sec_ff > RANGE_CAP && mask_ff[63:32] != 32'd0) sec_in = RANGE_CAP;
            st_in = S_RNG2;
         end
         S_RNG2: begin
            if (scale_ff == 20'd0) range_in = '0;
            else if (sec_ff[63:32] != 32'd0) range_in = '1;
            else range_in = 32'd0;
            st_in = S_RNGW;
         end
         S_RNGW: begin
            if (scale_ff != 20'd0 && sec_ff[63:32] == 32'd0)
               range_in = (prod[63:32] != 32'd0) ? 32'hFFFFFFFF : prod[31:0];
            st_in = S_ACC;
         end
         S_ACC: begin
            t_in = {32'd0, range_ff} * {32'd0, freq_ff};
            t_in = t_in >> 32;
            acc_in = 6'd32;
            st_in = S_ACC2;
         end
         S_ACC2: begin
            if (t_ff != 64'd0 && acc_ff != 6'd0) begin
               t_in = t_ff >> 1;
               acc_in = acc_ff - 6'd1;
            end else begin
               sh_in = 6'd32;
               st_in = S_SRCH;
            end
         end
         S_SRCH: begin
            dreq.start = 1'b1;
            dreq.dividend = ({32'd0, to_ff} << sh_ff) + {33'd0, freq_ff[31:1]};
            dreq.divisor = {32'd0, freq_ff};
            st_in = S_SRCHW;
         end
         S_SRCHW: begin
            if (drsp.done) begin
               mult_in = drsp.quotient[31:0];
               if (cand64 == 65'd0) begin
                  shift_in = sh_ff;
                  st_in = S_MARG;
               end else if (sh_ff == 6'd1) begin
                  shift_in = 6'd0;
                  st_in = S_MARG;
               end else begin
                  sh_in = sh_ff - 6'd1;
                  st_in = S_SRCH;
               end
            end
         end
         S_MARG: begin
            adj_in = adjust_of(mult_ff);
            if (margin_ff != 32'd0) begin
               st_in = S_HALF;
            end else if (scale_ff != 20'd0 && freq_ff != 32'd0) begin
               dreq.start = 1'b1;
               dreq.dividend = {32'd0, NS_PER_SEC};
               dreq.divisor = {44'd0, scale_ff} * {32'd0, freq_ff};
               st_in = S_MARGW;
            end else begin
               margin_in = DEFAULT_MARGIN;
               st_in = S_HALF;
            end
         end
         S_MARGW: begin
            if (drsp.done) begin
               margin_in = (drsp.quotient < {32'd0, MIN_MARGIN}) ? MIN_MARGIN
                         : drsp.quotient[31:0];
               st_in = S_HALF;
            end
         end
         S_HALF: begin
            if (freq_ff != 32'd0 && sum[32]) begin
               mult_in = mult_ff >> 1;
               adj_in = adjust_of(mult_ff >> 1);
               if (shift_ff != 6'd0) shift_in = shift_ff - 6'd1;
            end else begin
               st_in = S_MCYC;
            end
         end
         S_MCYC: begin
            if (sum == 33'd0) begin
               dz_in = 1'b1;
               cyc_in = mask_ff;
               st_in = S_NS;
            end else begin
               dreq.start = 1'b1;
               dreq.dividend = '1;
               dreq.divisor = {31'd0, sum};
               st_in = S_MCYCW;
            end
         end
         S_MCYCW: begin
            if (drsp.done) begin
               cyc_in = (drsp.quotient > mask_ff) ? mask_ff : drsp.quotient;
               st_in = S_NS;
            end
         end
         S_NS: begin
            ns_in = {32'd0, cyc_ff[63:32]} * {32'd0, diff};
            st_in = S_NS2;
         end
         S_NS2: begin
            ns_in = ((nsp + {ns_ff[31:0], 32'd0}) >> shift_ff) >> 1;
            st_in = S_DONE;
         end
         S_DONE: begin
            if (res_taken) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (go) begin
         mask_ff <= req_counter_mask;
         scale_ff <= req_scale;
         freq_ff <= req_freq;
      end
      margin_ff <= margin_in;
      mult_ff <= mult_in;
      shift_ff <= shift_in;
      to_ff <= to_in;
      range_ff <= range_in;
      adj_ff <= adj_in;
      acc_ff <= acc_in;
      sh_ff <= sh_in;
      sec_ff <= sec_in;
      t_ff <= t_in;
      cyc_ff <= cyc_in;
      ns_ff <= ns_in;
      dz_ff <= dz_in;
      if (reset) st_ff <= S_IDLE;
      else st_ff <= st_in;
   end

   assign res_valid  = (st_ff == S_DONE);
   assign res_mult   = mult_ff;
   assign res_shift  = shift_ff;
   assign res_adj    = adj_ff;
   assign res_maxcyc = cyc_ff;
   assign res_ns     = ns_ff;
   assign res_margin = margin_ff;
   assign res_ovf    = sum[32] || dz_ff;
endmodule
`default_nettype wire

// ===== design/clock_mult_shift_calc_core.sv =====
// Top level of the clock mult/shift calculation block
//
// Takes one counter description word on the req_ channel and returns one
// result word on the rsp_ channel: mult, shift, adjustment bound, max cycles,
// half the idle nanoseconds, margin and two warning flags.
// A word is accepted when req_valid is high and req_stall low; req_stall is
// high from acceptance until the result has been taken.
// All divisions run on one shared 64-bit restoring divider at one quotient
// bit per cycle. A word with nonzero freq needs up to 3 + 32 + 2 divisions.
// One word is in flight at a time.
// The result is held on the rsp_ ports while rsp_stall is high.
// Synchronous reset returns the sequencer to idle and drops any result.
`default_nettype none
module clock_mult_shift_calc_core
   import cmsc_pkg::*;
#(
   parameter int MAX_RANGE_SEC = 600
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_counter_mask,
   input  wire logic [19:0] req_scale,
   input  wire logic [31:0] req_freq,
   input  wire logic [31:0] req_given_margin,
   input  wire logic [31:0] req_preset_mult,
   input  wire logic [5:0]  req_preset_shift,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_mult_out,
   output logic [5:0]       rsp_shift_out,
   output logic [31:0]      rsp_max_adjust,
   output logic [63:0]      rsp_max_cycles_out,
   output logic [63:0]      rsp_max_idle_ns,
   output logic [31:0]      rsp_margin_out,
   output logic             rsp_adjust_overflow,
   output logic             rsp_margin_small
);
   div_req_type dreq;
   div_rsp_type drsp;

   cmsc_div u_div (
      .clock(clock), .reset(reset), .req(dreq), .rsp(drsp)
   );

   cmsc_seq #(.MAX_RANGE_SEC(MAX_RANGE_SEC)) u_seq (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_counter_mask(req_counter_mask), .req_scale(req_scale),
      .req_freq(req_freq), .req_given_margin(req_given_margin),
      .req_preset_mult(req_preset_mult), .req_preset_shift(req_preset_shift),
      .res_valid(rsp_valid), .res_taken(!rsp_stall),
      .res_mult(rsp_mult_out), .res_shift(rsp_shift_out), .res_adj(rsp_max_adjust),
      .res_maxcyc(rsp_max_cycles_out), .res_ns(rsp_max_idle_ns),
      .res_margin(rsp_margin_out), .res_ovf(rsp_adjust_overflow),
      .dreq(dreq), .drsp(drsp)
   );

   assign rsp_margin_small = (rsp_margin_out < MIN_MARGIN);

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_max_cycles_out))
      else $error("result dropped under stall");
   a_div_idle_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !drsp.busy) else $error("divider busy with result out");
endmodule
`default_nettype wire

// ===== dv/cmsc_checker.sv =====
// Result checker for the clock mult/shift calculation block
`timescale 1ns / 100ps
`default_nettype none
module cmsc_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [63:0] req_counter_mask,
   input  wire logic [19:0] req_scale,
   input  wire logic [31:0] req_freq,
   input  wire logic [31:0] req_given_margin,
   input  wire logic [31:0] req_preset_mult,
   input  wire logic [5:0]  req_preset_shift,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [31:0] rsp_mult_out,
   input  wire logic [5:0]  rsp_shift_out,
   input  wire logic [31:0] rsp_max_adjust,
   input  wire logic [63:0] rsp_max_cycles_out,
   input  wire logic [63:0] rsp_max_idle_ns,
   input  wire logic [31:0] rsp_margin_out,
   input  wire logic        rsp_adjust_overflow,
   input  wire logic        rsp_margin_small,
   output int               fail_count,
   output int               pending
);
   localparam logic [63:0] MAX_RANGE = 64'd600;
   localparam logic [63:0] ONE_SEC   = 64'd1000000000;
   localparam logic [63:0] MIN_MRG   = 64'd200000;
   localparam logic [63:0] DEF_MRG   = 64'd31250000;
   localparam logic [63:0] ALL32     = 64'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] mult;
      logic [5:0]  shift;
      logic [31:0] adj;
      logic [63:0] cycles;
      logic [63:0] idle_ns;
      logic [31:0] margin;
      logic        ovf;
      logic        small_mrg;
   } conv_type;

   conv_type conv_q[$];

   function automatic logic [31:0] eleven_pct(input logic [31:0] m);
      logic [63:0] p;
      begin
         p = {32'd0, m} * 64'd11;
         eleven_pct = 32'(p / 64'd100);
      end
   endfunction

   function automatic conv_type predict_conv(input logic [63:0] mask, input logic [19:0] scale,
                                             input logic [31:0] freq, input logic [31:0] gmargin,
                                             input logic [31:0] pmult, input logic [5:0] pshift);
      conv_type r;
      logic [63:0] sec, range, t, cand, sum, mc, ns;
      logic [31:0] to, mult, adj, margin;
      logic [5:0]  shift;
      int acc, sh;
      logic dz;
      begin
         mult = pmult; shift = pshift; dz = 1'b0;
         if (freq != 0) begin
            sec = mask / {32'd0, freq};
            if (scale != 0) begin
               sec = sec / {44'd0, scale};
               to = 32'(ONE_SEC / {44'd0, scale});
            end else begin
               sec = '1; to = '1; dz = 1'b1;
            end
            if (sec == 0) sec = 1;
            else if (sec > MAX_RANGE && mask > ALL32) sec = MAX_RANGE;
            if (scale == 0) range = 0;
            else if (sec > ALL32 / {44'd0, scale}) range = ALL32;
            else range = sec * {44'd0, scale};
            t = ({32'd0, range[31:0]} * {32'd0, freq}) >> 32;
            acc = 32;
            while (t != 0 && acc > 0) begin
               t = t >> 1; acc--;
            end
            cand = 0;
            for (sh = 32; sh > 0; sh--) begin
               cand = (({32'd0, to} << sh) + {33'd0, freq[31:1]}) / {32'd0, freq};
               if ((cand >> acc) == 0) break;
            end
            mult = cand[31:0]; shift = 6'(sh);
         end
         margin = gmargin;
         if (margin == 0) begin
            if (scale != 0 && freq != 0) begin
               t = ONE_SEC / ({44'd0, scale} * {32'd0, freq});
               margin = (t < MIN_MRG) ? MIN_MRG[31:0] : t[31:0];
            end else margin = DEF_MRG[31:0];
         end
         adj = eleven_pct(mult);
         while (freq != 0 && ({32'd0, mult} + {32'd0, adj}) > ALL32) begin
            mult = mult >> 1;
            if (shift > 0) shift--;
            adj = eleven_pct(mult);
         end
         sum = {32'd0, mult} + {32'd0, adj};
         if (sum == 0) begin
            mc = '1; dz = 1'b1;
         end else mc = 64'hFFFF_FFFF_FFFF_FFFF / sum;
         if (mc > mask) mc = mask;
         ns = (mc * {32'd0, mult - adj}) >> shift;
         r.mult = mult; r.shift = shift; r.adj = adj; r.cycles = mc;
         r.idle_ns = ns >> 1; r.margin = margin;
         r.ovf = (sum > ALL32) || dz;
         r.small_mrg = {32'd0, margin} < MIN_MRG;
         predict_conv = r;
      end
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      fail_count++;
   endtask

   assign pending = conv_q.size();

   always @(posedge clock) begin
      conv_type e;
      if (reset) begin
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall)
            conv_q.push_back(predict_conv(req_counter_mask, req_scale, req_freq,
                                          req_given_margin, req_preset_mult, req_preset_shift));
         if (rsp_valid && !rsp_stall) begin
            if (conv_q.size() == 0) begin
               report("unexpected word", 64'd1, 64'd0);
            end else begin
               e = conv_q.pop_front();
               if (rsp_mult_out !== e.mult) report("mult", rsp_mult_out, e.mult);
               if (rsp_shift_out !== e.shift) report("shift", rsp_shift_out, e.shift);
               if (rsp_max_adjust !== e.adj) report("adjust", rsp_max_adjust, e.adj);
               if (rsp_max_cycles_out !== e.cycles)
                  report("cycles", rsp_max_cycles_out, e.cycles);
               if (rsp_max_idle_ns !== e.idle_ns) report("idle_ns", rsp_max_idle_ns, e.idle_ns);
               if (rsp_margin_out !== e.margin) report("margin", rsp_margin_out, e.margin);
               if (rsp_adjust_overflow !== e.ovf) report("ovf", rsp_adjust_overflow, e.ovf);
               if (rsp_margin_small !== e.small_mrg)
                  report("small", rsp_margin_small, e.small_mrg);
            end
         end
      end
   end
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench top for the clock mult/shift calculation block
`timescale 1ns / 100ps
`default_nettype none
module tb;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_counter_mask = '0;
   logic [19:0] req_scale = 20'd1;
   logic [31:0] req_freq = '0;
   logic [31:0] req_given_margin = '0;
   logic [31:0] req_preset_mult = '0;
   logic [5:0]  req_preset_shift = '0;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_mult_out;
   logic [5:0]  rsp_shift_out;
   logic [31:0] rsp_max_adjust;
   logic [63:0] rsp_max_cycles_out;
   logic [63:0] rsp_max_idle_ns;
   logic [31:0] rsp_margin_out;
   logic        rsp_adjust_overflow;
   logic        rsp_margin_small;
   int          fail_count;
   int          pending;
   int          rsp_wait = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   clock_mult_shift_calc_core u_top (.*);

   cmsc_checker u_chk (.*);

   task automatic send_word(input logic [63:0] mask, input logic [19:0] scale,
                            input logic [31:0] freq, input logic [31:0] mrg,
                            input logic [31:0] pm, input logic [5:0] ps);
      int gap;
      begin
         gap = $urandom_range(0, 16);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid        <= 1'b1;
         req_counter_mask <= mask;
         req_scale        <= scale;
         req_freq         <= freq;
         req_given_margin <= mrg;
         req_preset_mult  <= pm;
         req_preset_shift <= ps;
         do @(posedge clock); while (req_stall);
      end
   endtask

   task automatic drain();
      begin
         req_valid <= 1'b0;
         @(posedge clock);
         wait (pending == 0);
      end
   endtask

   function automatic logic [63:0] rand_mask();
      int w;
      begin
         w = $urandom_range(1, 64);
         rand_mask = (w == 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << w) - 64'd1);
         if ($urandom_range(0, 5) == 0) rand_mask = {$urandom, $urandom};
      end
   endfunction

   assign rsp_stall = (rsp_wait != 0);

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) rsp_wait <= $urandom_range(0, 16);
      else if (rsp_valid && rsp_wait != 0) rsp_wait <= rsp_wait - 1;
   end

   initial begin
      logic [19:0] sc;
      logic [31:0] fq;
      int i;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_word('1, 20'd1, 32'd1000000000, 32'd0, 32'd0, 6'd0);
      send_word(64'hFFFF_FFFF, 20'd1, 32'd32768, 32'd0, 32'd0, 6'd0);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 20'd1000, 32'd24000, 32'd0, 32'd0, 6'd0);
      send_word('0, 20'd1, 32'd1, 32'd0, 32'd0, 6'd0);
      send_word('1, 20'd1000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 6'd0);
      send_word('1, 20'd0, 32'd1000, 32'd0, 32'd0, 6'd0);
      send_word('1, 20'hFFFFF, 32'd1, 32'd5, 32'd0, 6'd0);
      send_word(64'h0000_0001_0000_0000, 20'd1, 32'd3, 32'd0, 32'd0, 6'd0);
      send_word('1, 20'd1, 32'd0, 32'd0, 32'd0, 6'd0);
      send_word('1, 20'd1, 32'd0, 32'd0, 32'hFFFF_FFFF, 6'd32);
      send_word(64'hFF, 20'd1, 32'd0, 32'd0, 32'd4000000000, 6'd63);
      send_word('1, 20'd1, 32'd0, 32'd12345, 32'd1, 6'd0);
      send_word('1, 20'd0, 32'd0, 32'd0, 32'd7, 6'd3);
      send_word('1, 20'd1, 32'd2, 32'd0, 32'd0, 6'd0);
      send_word(64'hFFFF_FFFF, 20'd7, 32'h7FFF_FFFF, 32'd0, 32'd0, 6'd0);
      drain();
      for (i = 0; i < 140; i++) begin
         sc = ($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, 1000000)) :
              (($urandom_range(0, 1) == 1) ? 20'd1 : 20'd1000);
         if ($urandom_range(0, 30) == 0) sc = 20'($urandom);
         fq = ($urandom_range(0, 6) == 0) ? 32'd0 : $urandom >> $urandom_range(0, 31);
         send_word(rand_mask(), sc, fq,
                   ($urandom_range(0, 2) == 0) ? $urandom : 32'd0,
                   $urandom >> $urandom_range(0, 31), 6'($urandom));
         if (i == 70) drain();
      end
      drain();
      repeat (3000) @(posedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #100ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
design/cmsc_pkg.sv
design/cmsc_div.sv
design/cmsc_seq.sv
design/clock_mult_shift_calc_core.sv
dv/cmsc_checker.sv
dv/tb.sv
